>>> sv/imu_frame_word_extractor_defines.svh
// assertion macros shared by the frame word extractor
`ifndef IMU_FRAME_WORD_EXTRACTOR_DEFINES_SVH
`define IMU_FRAME_WORD_EXTRACTOR_DEFINES_SVH

// property checked at every rising clock edge outside reset
`define IFWE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define IFWE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/ifwe_pkg.sv
// types and constants of the frame word extractor
package ifwe_pkg;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 32;
  localparam int INDEX_W = 3;
  localparam int POS_W   = 9;
  localparam int LEFT_W  = 4;
  localparam int PROG_W  = 2;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [INDEX_W-1:0] word_index_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [LEFT_W-1:0]  left_t;
  typedef logic [PROG_W-1:0]  prog_t;

  // register map, index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_PREAMBLE = 2'd0,
    REG_BUS_ID   = 2'd1,
    REG_DATA_MSG = 2'd2,
    REG_SIZE_TAG = 2'd3
  } reg_index_t;

  localparam byte_t PREAMBLE_RESET = 8'd250;
  localparam byte_t BUS_ID_RESET   = 8'd255;
  localparam byte_t DATA_MSG_RESET = 8'd54;
  localparam byte_t SIZE_TAG_RESET = 8'd12;
  localparam byte_t LENGTH_RESET   = 8'd5;

  // frame positions, first byte is position 1
  localparam pos_t POS_PREAMBLE    = 9'd1;
  localparam pos_t POS_BUS_ID      = 9'd2;
  localparam pos_t POS_MSG_ID      = 9'd3;
  localparam pos_t POS_LENGTH      = 9'd4;
  localparam pos_t SIZE_TAG_POS    = 9'd19;
  localparam pos_t ANGLE_START_POS = 9'd20;
  localparam pos_t ACCEL_START_POS = 9'd35;
  localparam pos_t LENGTH_OFFSET   = 9'd4;
  localparam pos_t MAX_FRAME_POS   = 9'd259;

  localparam prog_t PROG_MSG_ID = 2'd2;
  localparam prog_t PROG_DONE   = 2'd3;

  // bytes left in a set of three words, and the counts at which a word completes
  localparam left_t WORD_SET_BYTES = 4'd12;
  localparam left_t SLOT0_LEFT     = 4'd8;
  localparam left_t SLOT1_LEFT     = 4'd4;
  localparam left_t SLOT2_LEFT     = 4'd0;

  localparam word_index_t ACCEL_INDEX_BASE = 3'd3;
  localparam word_index_t LAST_INDEX       = 3'd5;

endpackage

>>> sv/ifwe_byte_if.sv
// valid/ready channel carrying one received byte
interface ifwe_byte_if;
  import ifwe_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> sv/ifwe_word_if.sv
// valid/ready channel carrying one assembled word and its index
interface ifwe_word_if;
  import ifwe_pkg::*;

  logic        valid;
  logic        ready;
  word_index_t word_index;
  word_t       word_bits;

  modport source (output valid, output word_index, output word_bits, input ready);
  modport sink (input valid, input word_index, input word_bits, output ready);
endinterface

>>> sv/imu_frame_word_extractor.sv
// sensor frame parser that extracts angle and acceleration words
//
//   channel    dir  handshake      payload
//   rx_chan    in   valid/ready    rx_byte[7:0]
//   word_chan  out  valid/ready    word_index[2:0], word_bits[31:0]
//   apb        in   psel/penable   paddr[3:0], pwdata/prdata[31:0]
//
// one byte is taken per cycle while rx_chan.ready is high; its result lands in the output register at the same edge
// the parse state update is a single compare/shift/decrement step, no loop across cycles
// rx_chan.ready drops only while a result waits in the output register and is not taken
// synchronous reset restores the register defaults and clears the frame position
// no clearing pass: all state is plain flip-flops
`include "imu_frame_word_extractor_defines.svh"

module imu_frame_word_extractor (
  input  logic                       clk,
  input  logic                       rst,
  ifwe_byte_if.sink                  rx_chan,
  ifwe_word_if.source                word_chan,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ifwe_pkg::ADDR_W-1:0] paddr,
  input  logic [ifwe_pkg::DATA_W-1:0] pwdata,
  output logic [ifwe_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import ifwe_pkg::*;

  // configuration registers
  byte_t preamble_byte;
  byte_t bus_id_byte;
  byte_t data_message_id;
  byte_t size_tag_value;

  // parse state
  pos_t  byte_position;
  prog_t header_progress;
  byte_t message_id;
  byte_t payload_length;
  word_t shift_word;
  left_t angle_bytes_left;
  left_t accel_bytes_left;

  pos_t  byte_position_next;
  prog_t header_progress_next;
  byte_t message_id_next;
  byte_t payload_length_next;
  word_t shift_word_next;
  left_t angle_bytes_left_next;
  left_t accel_bytes_left_next;

  // output register
  logic        out_valid;
  word_index_t out_index;
  word_t       out_bits;

  logic        have;
  word_index_t have_index;
  word_t       have_bits;

  logic       rx_take;
  logic       cfg_write;
  reg_index_t cfg_index;
  byte_t      b;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[3:2]);

  always_comb begin
    case (cfg_index)
      REG_PREAMBLE: prdata = {24'd0, preamble_byte};
      REG_BUS_ID:   prdata = {24'd0, bus_id_byte};
      REG_DATA_MSG: prdata = {24'd0, data_message_id};
      REG_SIZE_TAG: prdata = {24'd0, size_tag_value};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_byte   <= PREAMBLE_RESET;
      bus_id_byte     <= BUS_ID_RESET;
      data_message_id <= DATA_MSG_RESET;
      size_tag_value  <= SIZE_TAG_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PREAMBLE: preamble_byte   <= pwdata[7:0];
        REG_BUS_ID:   bus_id_byte     <= pwdata[7:0];
        REG_DATA_MSG: data_message_id <= pwdata[7:0];
        REG_SIZE_TAG: size_tag_value  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: take a byte whenever the output register is free or draining
  // ---------------------------------------------------------------------------
  assign rx_chan.ready = !out_valid || word_chan.ready;
  assign rx_take       = rx_chan.valid && rx_chan.ready;
  assign b             = rx_chan.rx_byte;

  // word slot within a set of three, from the bytes still to come
  function automatic word_index_t slot_of(input left_t left);
    word_index_t slot;
    case (left)
      SLOT0_LEFT: slot = 3'd0;
      SLOT1_LEFT: slot = 3'd1;
      default:    slot = 3'd2;
    endcase
    return slot;
  endfunction

  // ---------------------------------------------------------------------------
  // per-byte parse step
  // ---------------------------------------------------------------------------
  always_comb begin
    byte_position_next    = byte_position + 9'd1;
    header_progress_next  = header_progress;
    message_id_next       = message_id;
    payload_length_next   = payload_length;
    shift_word_next       = shift_word;
    angle_bytes_left_next = angle_bytes_left;
    accel_bytes_left_next = accel_bytes_left;
    have                  = 1'b0;
    have_index            = '0;
    have_bits             = '0;

    if (b == preamble_byte && byte_position_next == POS_PREAMBLE) begin
      header_progress_next = header_progress + 2'd1;
    end else if (b == bus_id_byte && byte_position_next == POS_BUS_ID) begin
      header_progress_next = header_progress + 2'd1;
    end else if (byte_position_next == POS_MSG_ID && header_progress == PROG_MSG_ID) begin
      header_progress_next = PROG_DONE;
      message_id_next      = b;
    end else if (header_progress == PROG_DONE && message_id == data_message_id) begin
      if (byte_position_next == POS_LENGTH) begin
        payload_length_next = b;
      end
      // size tag arms the angle set
      if (byte_position_next == SIZE_TAG_POS && b == size_tag_value) begin
        angle_bytes_left_next = WORD_SET_BYTES;
      end
      if (angle_bytes_left_next != '0 && byte_position_next >= ANGLE_START_POS) begin
        shift_word_next       = {shift_word_next[23:0], b};
        angle_bytes_left_next = angle_bytes_left_next - 4'd1;
        if (angle_bytes_left_next == SLOT0_LEFT || angle_bytes_left_next == SLOT1_LEFT ||
            angle_bytes_left_next == SLOT2_LEFT) begin
          have            = 1'b1;
          have_index      = slot_of(angle_bytes_left_next);
          have_bits       = shift_word_next;
          shift_word_next = '0;
          // last angle word arms the acceleration set
          if (angle_bytes_left_next == SLOT2_LEFT) begin
            accel_bytes_left_next = WORD_SET_BYTES;
          end
        end
      end
      if (byte_position_next >= ACCEL_START_POS && accel_bytes_left_next != '0) begin
        shift_word_next       = {shift_word_next[23:0], b};
        accel_bytes_left_next = accel_bytes_left_next - 4'd1;
        if (accel_bytes_left_next == SLOT0_LEFT || accel_bytes_left_next == SLOT1_LEFT ||
            accel_bytes_left_next == SLOT2_LEFT) begin
          have            = 1'b1;
          have_index      = slot_of(accel_bytes_left_next) + ACCEL_INDEX_BASE;
          have_bits       = shift_word_next;
          shift_word_next = '0;
        end
      end
    end else begin
      // header mismatch or foreign message: start over
      byte_position_next   = '0;
      header_progress_next = '0;
    end

    // frame end at length + 4, a zero length ends at the length byte
    if (byte_position_next == ({1'b0, payload_length_next} + LENGTH_OFFSET)) begin
      byte_position_next   = '0;
      header_progress_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      header_progress  <= '0;
      message_id       <= '0;
      payload_length   <= LENGTH_RESET;
      shift_word       <= '0;
      angle_bytes_left <= '0;
      accel_bytes_left <= '0;
    end else if (rx_take) begin
      byte_position    <= byte_position_next;
      header_progress  <= header_progress_next;
      message_id       <= message_id_next;
      payload_length   <= payload_length_next;
      shift_word       <= shift_word_next;
      angle_bytes_left <= angle_bytes_left_next;
      accel_bytes_left <= accel_bytes_left_next;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rx_take && have) begin
      out_valid <= 1'b1;
    end else if (word_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (rx_take && have) begin
      out_index <= have_index;
      out_bits  <= have_bits;
    end
  end

  assign word_chan.valid      = out_valid;
  assign word_chan.word_index = out_index;
  assign word_chan.word_bits  = out_bits;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `IFWE_ASSERT(a_index_range, !out_valid || out_index <= LAST_INDEX, "word index beyond set")
  `IFWE_ASSERT(a_pos_bound, byte_position <= MAX_FRAME_POS, "byte position past frame end")
  `IFWE_ASSERT(a_header_pos, header_progress != PROG_DONE || byte_position >= POS_MSG_ID,
      "header complete before message id position")
  `IFWE_ASSERT_NEXT(a_result_loaded, rx_take && have, out_valid && out_index == $past(have_index),
      "result lost on its way to the output register")

endmodule
